[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned WORD_BITS_DEF = 64;
    localparam int unsigned IN_W          = 64;
    localparam int unsigned WIDE_W        = 128;

    typedef enum logic [2:0] {
        OP_NORM = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_INV  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO_DEN = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [63:0] a_num;
        logic signed [63:0] a_den;
        logic signed [63:0] b_num;
        logic signed [63:0] b_den;
    } in_beat_t;

    typedef struct packed {
        logic signed [63:0] res_num;
        logic [62:0]        res_den;
        logic [1:0]         status;
    } out_beat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_COMB,
        S_G_CHK,
        S_G_TWO,
        S_G_AODD,
        S_G_BODD,
        S_G_SUB,
        S_G_SHL,
        S_DIVN,
        S_DIVD,
        S_FIN,
        S_OUT
    } state_t;

    // One multiply request to the multiplier
    typedef struct packed {
        logic        start;
        logic [63:0] x;
        logic [63:0] y;
    } mul_req_t;

    typedef struct packed {
        logic         done;
        logic [127:0] p;
    } mul_rsp_t;

endpackage

[hw/rtl/rational_arithmetic_unit.sv]
// Multiply and divide run two products through the shared multiplier, add and
// subtract three; binary GCD runs one shift or subtract per cycle on the 128-bit
// products; then two restoring divides (numerator, denominator) and a finish step.
// A zero denominator beat gives its result the cycle after it is taken. One item at a
// time, s_ready only when idle. Reset (synchronous, aresetn low): idle, no result.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact signed fraction arithmetic with GCD reduction and range check.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

    state_t       state_reg, state_next;
    logic [2:0]   op_reg;
    logic [63:0]  na_reg, da_reg, nb_reg, db_reg;
    logic         sna_reg, sda_reg, snb_reg, sdb_reg;
    logic [127:0] t1_reg, t1_next;      // first product / numerator
    logic [127:0] num_reg, num_next;
    logic [127:0] den_reg, den_next;
    logic [127:0] ga_reg, ga_next, gb_reg, gb_next;
    logic [6:0]   k_reg, k_next;
    logic [127:0] q_reg, q_next, r_reg, r_next;
    logic [6:0]   i_reg, i_next;
    logic         sign_reg, sign_next;
    logic         mphase_reg, mphase_next;
    out_beat_t    out_reg, out_next;
    mul_req_t     mreq;
    mul_rsp_t     mrsp;

    logic [63:0]  in_na, in_da, in_nb, in_db;
    logic         in_bin, in_err;
    logic [127:0] cmp_a, cmp_b;
    logic         swap;
    logic [127:0] sub_a, sub_b, sub_y;
    logic         sub_ge;
    logic [127:0] rsh;
    logic         rcarry;
    logic [127:0] dsrc;
    logic         s1, s2;

    function automatic logic [63:0] mag(input logic [63:0] v);
        mag = v[63] ? (64'd0 - v) : v;
    endfunction

    rau_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .rsp     (mrsp)
    );

    assign in_na  = mag(s_data.a_num);
    assign in_da  = mag(s_data.a_den);
    assign in_nb  = mag(s_data.b_num);
    assign in_db  = mag(s_data.b_den);
    assign in_bin = (s_data.operation >= 3'(OP_ADD)) && (s_data.operation <= 3'(OP_DIV));
    assign in_err = (in_da == 64'd0) || (in_bin && in_db == 64'd0)
                 || (s_data.operation == 3'(OP_DIV) && in_nb == 64'd0)
                 || (s_data.operation == 3'(OP_INV) && in_na == 64'd0);

    assign s1 = sna_reg ^ sda_reg;
    assign s2 = snb_reg ^ sdb_reg ^ (op_reg == 3'(OP_SUB));

    assign dsrc   = (state_reg == S_DIVN) ? num_reg : den_reg;
    assign rcarry = r_reg[127];
    assign rsh    = {r_reg[126:0], dsrc[i_reg]};

    // Shared 128-bit compare/subtract; swapped to an absolute difference
    // for the combine and GCD steps, straight for the divide.
    always_comb begin
        cmp_a = '0;
        cmp_b = '0;
        swap  = 1'b0;
        case (state_reg)
            S_COMB: begin
                cmp_a = t1_reg;
                cmp_b = mrsp.p;
                swap  = 1'b1;
            end
            S_G_SUB: begin
                cmp_a = gb_reg;
                cmp_b = ga_reg;
                swap  = 1'b1;
            end
            S_DIVN, S_DIVD: begin
                cmp_a = rsh;
                cmp_b = ga_reg;
            end
            default: ;
        endcase
    end

    assign sub_ge = cmp_a >= cmp_b;
    assign sub_a  = (swap && !sub_ge) ? cmp_b : cmp_a;
    assign sub_b  = (swap && !sub_ge) ? cmp_a : cmp_b;
    assign sub_y  = sub_a - sub_b;

    always_comb begin
        state_next  = state_reg;
        t1_next     = t1_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        ga_next     = ga_reg;
        gb_next     = gb_reg;
        k_next      = k_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        i_next      = i_reg;
        sign_next   = sign_reg;
        mphase_next = mphase_reg;
        out_next    = out_reg;
        mreq        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (in_err) begin
                        out_next   = '0;
                        out_next.status = ST_ZERO_DEN;
                        state_next = S_OUT;
                    end else if (in_bin) begin
                        mreq.start = 1'b1;
                        case (s_data.operation)
                            3'(OP_MUL): begin mreq.x = in_na; mreq.y = in_nb; end
                            default:    begin mreq.x = in_na; mreq.y = in_db; end
                        endcase
                        state_next = S_MUL1;
                    end else begin
                        if (s_data.operation == 3'(OP_INV)) begin
                            num_next = {64'd0, in_da};
                            den_next = {64'd0, in_na};
                        end else begin
                            num_next = {64'd0, in_na};
                            den_next = {64'd0, in_da};
                        end
                        sign_next  = s_data.a_num[63] ^ s_data.a_den[63];
                        state_next = S_G_CHK;
                    end
                end
            end
            S_MUL1: begin
                if (mrsp.done) begin
                    t1_next    = mrsp.p;
                    mreq.start = 1'b1;
                    case (op_reg)
                        3'(OP_MUL): begin mreq.x = da_reg; mreq.y = db_reg; end
                        3'(OP_DIV): begin mreq.x = da_reg; mreq.y = nb_reg; end
                        default:    begin mreq.x = nb_reg; mreq.y = da_reg; end
                    endcase
                    mphase_next = 1'b0;
                    state_next  = S_MUL2;
                end
            end
            S_MUL2: begin
                if (mrsp.done) begin
                    if (op_reg == 3'(OP_ADD) || op_reg == 3'(OP_SUB)) begin
                        state_next = S_COMB;
                    end else begin
                        num_next   = t1_reg;
                        den_next   = mrsp.p;
                        sign_next  = sna_reg ^ sda_reg ^ snb_reg ^ sdb_reg;
                        state_next = S_G_CHK;
                    end
                end
            end
            S_COMB: begin
                // mrsp.p holds nb*da here; start da*db next
                if (!mphase_reg) begin
                    if (s1 == s2) begin
                        num_next  = t1_reg + mrsp.p;
                        sign_next = s1;
                    end else begin
                        num_next  = sub_y;
                        sign_next = sub_ge ? s1 : s2;
                    end
                    mreq.start  = 1'b1;
                    mreq.x      = da_reg;
                    mreq.y      = db_reg;
                    mphase_next = 1'b1;
                end else if (mrsp.done) begin
                    den_next   = mrsp.p;
                    state_next = S_G_CHK;
                end
            end
            S_G_CHK: begin
                ga_next = num_reg;
                gb_next = den_reg;
                k_next  = '0;
                if (num_reg == '0) begin
                    ga_next    = den_reg;
                    state_next = S_DIVN;
                end else if (den_reg == '0) begin
                    state_next = S_DIVN;
                end else begin
                    state_next = S_G_TWO;
                end
                q_next = '0;
                r_next = '0;
                i_next = 7'd127;
            end
            S_G_TWO: begin
                if (!ga_reg[0] && !gb_reg[0]) begin
                    ga_next = ga_reg >> 1;
                    gb_next = gb_reg >> 1;
                    k_next  = k_reg + 7'd1;
                end else begin
                    state_next = S_G_AODD;
                end
            end
            S_G_AODD: begin
                if (!ga_reg[0]) ga_next = ga_reg >> 1;
                else state_next = S_G_BODD;
            end
            S_G_BODD: begin
                if (!gb_reg[0]) gb_next = gb_reg >> 1;
                else state_next = S_G_SUB;
            end
            S_G_SUB: begin
                if (!sub_ge) ga_next = gb_reg;
                gb_next = sub_y;
                state_next = (sub_y == '0) ? S_G_SHL : S_G_BODD;
            end
            S_G_SHL: begin
                if (k_reg != '0) begin
                    ga_next = ga_reg << 1;
                    k_next  = k_reg - 7'd1;
                end else begin
                    q_next     = '0;
                    r_next     = '0;
                    i_next     = 7'd127;
                    state_next = S_DIVN;
                end
            end
            S_DIVN, S_DIVD: begin
                r_next = rsh;
                if (rcarry || sub_ge) begin
                    r_next = sub_y;
                    q_next = q_reg | (128'd1 << i_reg);
                end
                i_next = i_reg - 7'd1;
                if (i_reg == 7'd0) begin
                    i_next = 7'd127;
                    if (state_reg == S_DIVN) begin
                        num_next   = q_next;
                        q_next     = '0;
                        r_next     = '0;
                        state_next = S_DIVD;
                    end else begin
                        den_next   = q_next;
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN: begin
                out_next = '0;
                if (num_reg == '0) sign_next = 1'b0;
                state_next = S_OUT;
                if ((num_reg[127:64] != '0)
                    || ((num_reg == '0 ? 1'b0 : sign_reg)
                        ? (num_reg[63:0] > LIM) : (num_reg[63:0] >= LIM))
                    || (den_reg[127:64] != '0) || (den_reg[63:0] >= LIM)) begin
                    out_next.status = ST_OVERFLOW;
                end else begin
                    out_next.res_num = (sign_reg && num_reg != '0)
                                     ? (64'd0 - num_reg[63:0]) : num_reg[63:0];
                    out_next.res_den = den_reg[62:0];
                    out_next.status  = ST_OK;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == S_IDLE && s_valid) begin
            op_reg  <= s_data.operation;
            na_reg  <= in_na;
            da_reg  <= in_da;
            nb_reg  <= in_nb;
            db_reg  <= in_db;
            sna_reg <= s_data.a_num[63];
            sda_reg <= s_data.a_den[63];
            snb_reg <= s_data.b_num[63];
            sdb_reg <= s_data.b_den[63];
        end
        t1_reg     <= t1_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        ga_reg     <= ga_next;
        gb_reg     <= gb_next;
        k_reg      <= k_next;
        q_reg      <= q_next;
        r_reg      <= r_next;
        i_reg      <= i_next;
        sign_reg   <= sign_next;
        mphase_reg <= mphase_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.res_num == '0 && m_data.res_den == '0)
        else $error("error result not zero");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |-> m_data.res_den != '0)
        else $error("ok result with zero denominator");
    a_done_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> s_ready) else $error("no return to idle");
`endif

endmodule

[hw/rtl/rau_mul.sv]
// ----------------------------------------------------------------------------
// rau_mul
// 64x64 unsigned multiplier: one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module rau_mul
    import rau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic [63:0]  x_reg, y_reg;
    logic [127:0] acc_reg, acc_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [31:0]  xs, ys;
    logic [63:0]  pp_reg;
    logic [63:0]  pp_next;
    logic [1:0]   sel_reg;

    always_comb begin
        xs = cnt_reg[1] ? x_reg[63:32] : x_reg[31:0];
        ys = cnt_reg[0] ? y_reg[63:32] : y_reg[31:0];
        pp_next = 64'(xs) * 64'(ys);
    end

    // Each partial product is multiplied, registered in pp_reg, then accumulated shifted.
    always_comb begin
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg != 3'd0) begin
                acc_next = acc_reg + ({64'd0, pp_reg} << (7'(sel_reg[1]) * 7'd32
                                                        + 7'(sel_reg[0]) * 7'd32));
            end
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        pp_reg  <= pp_next;
        sel_reg <= cnt_reg[1:0];
        if (req.start) begin
            x_reg <= req.x;
            y_reg <= req.y;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

endmodule

[verif/rational_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_tb
// Drives signed fraction operations through the unit and compares every
// result beat against a behavioral model built on 128-bit integer arithmetic.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int unsigned WB         = 64;
    localparam int          STALL_LIMIT = 20000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    out_beat_t fraction_q[$];
    int        errors = 0;
    int        n_sent = 0;
    int        n_recv = 0;
    int        idle_cycles = 0;
    bit        hold_off = 1'b0;
    bit        sink_idle_en = 1'b1;
    bit        src_gaps_en = 1'b1;
    int        burst_left = 0;
    int        op_count[8];
    int        stat_count[3];

    rational_arithmetic_unit #(.WORD_BITS(WB)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic [127:0] gcd128(logic [127:0] a, logic [127:0] b);
        logic [127:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic out_beat_t predict_fraction(in_beat_t x);
        out_beat_t r;
        logic [63:0] na, da, nb, db;
        logic sna, sda, snb, sdb, sgn, s1, s2, bin;
        logic [127:0] num, den, t1, t2, g, lim;
        logic [2:0] op;
        op = x.operation;
        sna = x.a_num[63]; sda = x.a_den[63]; snb = x.b_num[63]; sdb = x.b_den[63];
        na = sna ? -x.a_num : x.a_num;
        da = sda ? -x.a_den : x.a_den;
        nb = snb ? -x.b_num : x.b_num;
        db = sdb ? -x.b_den : x.b_den;
        bin = (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) || (op == OP_DIV);
        r = '0;
        if (da == 0 || (bin && db == 0) || (op == OP_DIV && nb == 0)
                || (op == OP_INV && na == 0)) begin
            r.status = ST_ZERO_DEN;
            return r;
        end
        case (op)
            OP_ADD, OP_SUB: begin
                t1 = 128'(na) * 128'(db);
                t2 = 128'(nb) * 128'(da);
                s1 = sna ^ sda;
                s2 = snb ^ sdb ^ (op == OP_SUB);
                if (s1 == s2) begin
                    num = t1 + t2; sgn = s1;
                end else if (t1 >= t2) begin
                    num = t1 - t2; sgn = s1;
                end else begin
                    num = t2 - t1; sgn = s2;
                end
                den = 128'(da) * 128'(db);
            end
            OP_MUL: begin
                num = 128'(na) * 128'(nb); den = 128'(da) * 128'(db);
                sgn = sna ^ sda ^ snb ^ sdb;
            end
            OP_DIV: begin
                num = 128'(na) * 128'(db); den = 128'(da) * 128'(nb);
                sgn = sna ^ sda ^ snb ^ sdb;
            end
            OP_INV: begin
                num = 128'(da); den = 128'(na); sgn = sna ^ sda;
            end
            default: begin
                num = 128'(na); den = 128'(da); sgn = sna ^ sda;
            end
        endcase
        g = gcd128(num, den);
        num = num / g;
        den = den / g;
        if (num == 0) sgn = 1'b0;
        lim = 128'(1) << (WB - 1);
        if ((sgn ? num > lim : num >= lim) || den >= lim) begin
            r.status = ST_OVERFLOW;
            return r;
        end
        r.res_num = sgn ? -num[63:0] : num[63:0];
        r.res_den = den[62:0];
        r.status  = ST_OK;
        return r;
    endfunction

    // Offer one beat; valid stays up until accepted and drops only for a gap or when draining.
    task automatic send_fraction(logic [2:0] op, logic [63:0] an, logic [63:0] ad,
                                 logic [63:0] bn, logic [63:0] bd);
        in_beat_t x;
        int       gap;
        x.operation = op; x.a_num = an; x.a_den = ad; x.b_num = bn; x.b_den = bd;
        if (src_gaps_en) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 8);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_data  <= x;
        fraction_q.push_back(predict_fraction(x));
        op_count[op]++;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        n_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (fraction_q.size() != 0) @(posedge aclk);
    endtask

    // Operand values biased toward edges and small magnitudes.
    function automatic logic [63:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'($signed($urandom_range(0, 6)) - 3);
            3, 4: return 64'($signed($urandom_range(0, 200)) - 100);
            5: return {$urandom, $urandom};
            6: return 64'($signed({$urandom, $urandom}) >>> $urandom_range(1, 62));
            default: return 64'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    task automatic test_directed();
        logic [63:0] mn, mx;
        mn = 64'h8000_0000_0000_0000;
        mx = 64'h7FFF_FFFF_FFFF_FFFF;
        send_fraction(OP_NORM, 6, -4, 0, 0);
        send_fraction(OP_NORM, 0, -7, 0, 0);
        send_fraction(OP_NORM, 5, 0, 0, 0);
        send_fraction(OP_NORM, mn, 1, 0, 0);
        send_fraction(OP_NORM, mn, -1, 0, 0);
        send_fraction(OP_NORM, 1, mn, 0, 0);
        send_fraction(OP_NORM, mx, mx, ~64'd0, ~64'd0);
        send_fraction(OP_ADD, 1, 2, 1, 3);
        send_fraction(OP_ADD, 1, 3, 0, 0);
        send_fraction(OP_ADD, mx, 1, mx, 1);
        send_fraction(OP_ADD, mx, mx - 1, mn, mx);
        send_fraction(OP_SUB, 1, 2, 1, 2);
        send_fraction(OP_SUB, mn, 1, 1, 1);
        send_fraction(OP_SUB, -3, 4, 5, -6);
        send_fraction(OP_MUL, mn, 1, -1, 1);
        send_fraction(OP_MUL, mx, 3, 3, mx);
        send_fraction(OP_MUL, 2, 3, 4, 0);
        send_fraction(OP_DIV, 2, 3, 0, 5);
        send_fraction(OP_DIV, -2, 3, 4, -9);
        send_fraction(OP_DIV, mn, mx, mn, mx);
        send_fraction(OP_INV, 0, 5, 0, 0);
        send_fraction(OP_INV, -6, 4, 0, 0);
        send_fraction(OP_INV, 1, mn, 0, 0);
        send_fraction(3'd6, 10, 4, 1, 1);
        send_fraction(3'd7, -9, -3, 0, 0);
        wait_drained();
    endtask

    task automatic test_random(int count);
        logic [2:0] op;
        for (int i = 0; i < count; i++) begin
            op = $urandom_range(0, 99) < 95 ? 3'($urandom_range(0, 5)) : 3'($urandom_range(6, 7));
            send_fraction(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
        end
    endtask

    // Receiver holds off while the sender keeps offering beats.
    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(6);
        join
        wait_drained();
    endtask

    task automatic test_no_idle();
        src_gaps_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random(40);
        src_gaps_en = 1'b1;
        sink_idle_en = 1'b1;
        wait_drained();
    endtask

    // Receiver stall pattern: its own rhythm, forced low during hold-off.
    always @(posedge aclk) begin
        if (hold_off)
            m_ready <= 1'b0;
        else if (!sink_idle_en)
            m_ready <= 1'b1;
        else
            m_ready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge aclk) begin
        out_beat_t e;
        if (aresetn && m_valid && m_ready) begin
            n_recv++;
            if (fraction_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                e = fraction_q.pop_front();
                if (m_data.status < 3) stat_count[m_data.status]++;
                if (m_data.res_num !== e.res_num) begin
                    $error("res_num exp %0d got %0d", $signed(e.res_num), $signed(m_data.res_num));
                    errors++;
                end
                if (m_data.res_den !== e.res_den) begin
                    $error("res_den exp %0d got %0d", e.res_den, m_data.res_den);
                    errors++;
                end
                if (m_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, m_data.status);
                    errors++;
                end
            end
        end
    end

    // Watchdog: long runs with no accepted beat on either side.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("rational_arithmetic_unit_tb failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_no_idle();
        test_random(750);
        wait_drained();
        repeat (2000) @(posedge aclk);
        $display("Sent %0d beats, received %0d; ops norm/add/sub/mul/div/inv %0d/%0d/%0d/%0d/%0d/%0d",
                 n_sent, n_recv, op_count[0], op_count[1], op_count[2], op_count[3],
                 op_count[4], op_count[5]);
        $display("Status ok %0d, zero denominator %0d, overflow %0d",
                 stat_count[0], stat_count[1], stat_count[2]);
        if (errors == 0 && fraction_q.size() == 0)
            $display("rational_arithmetic_unit_tb passed");
        else
            $display("rational_arithmetic_unit_tb failed");
        $finish;
    end

endmodule
